[hdl/assert_macros.svh]
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

[hdl/uf2a_pkg.sv]
package uf2a_pkg;

	localparam logic [6:0] CH_DOT   = 7'h2e;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_NUL   = 7'h00;

	typedef struct packed {
		logic [6:0] folded_char;
		logic [7:0] char_count;
		logic       end_of_text;
		logic       last_in_run;
	} result_t;

	// All results caused by one accepted byte.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} record_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [6:0] fold_cp(input logic [20:0] cp);
		logic [6:0] ch;
		ch = CH_DOT;
		if (cp >= 21'h0c0 && cp <= 21'h0c6) ch = 7'h41;
		else if (cp == 21'h0c7) ch = 7'h43;
		else if (cp >= 21'h0c8 && cp <= 21'h0cb) ch = 7'h45;
		else if (cp >= 21'h0cc && cp <= 21'h0cf) ch = 7'h49;
		else if (cp == 21'h0d1) ch = 7'h4e;
		else if ((cp >= 21'h0d2 && cp <= 21'h0d6) || cp == 21'h0d8) ch = 7'h4f;
		else if (cp >= 21'h0d9 && cp <= 21'h0dc) ch = 7'h55;
		else if (cp == 21'h0dd) ch = 7'h59;
		else if (cp == 21'h0df) ch = 7'h73;
		else if (cp >= 21'h0e0 && cp <= 21'h0e6) ch = 7'h61;
		else if (cp == 21'h0e7) ch = 7'h63;
		else if (cp >= 21'h0e8 && cp <= 21'h0eb) ch = 7'h65;
		else if (cp >= 21'h0ec && cp <= 21'h0ef) ch = 7'h69;
		else if (cp == 21'h0f1) ch = 7'h6e;
		else if ((cp >= 21'h0f2 && cp <= 21'h0f6) || cp == 21'h0f8) ch = 7'h6f;
		else if (cp >= 21'h0f9 && cp <= 21'h0fc) ch = 7'h75;
		else if (cp == 21'h0fd || cp == 21'h0ff) ch = 7'h79;
		else if (cp == 21'h0a0) ch = 7'h20;
		else if (cp == 21'h2018 || cp == 21'h2019) ch = 7'h27;
		else if (cp == 21'h201c || cp == 21'h201d) ch = 7'h22;
		else if (cp == 21'h2013 || cp == 21'h2014) ch = 7'h2d;
		else if (cp == 21'h2026) ch = 7'h2e;
		else if (cp == 21'h2022) ch = 7'h2a;
		return ch;
	endfunction

endpackage

[hdl/uf2a_front.sv]
module uf2a_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [7:0]           cfg_data,
	input  logic                 accept,
	input  logic [7:0]           text_byte,
	output logic                 push,
	output uf2a_pkg::record_t    rec
);

	logic [7:0]  maxlen_q;
	logic [1:0]  need_q, need_d;
	logic [20:0] acc_q, acc_d;
	logic [7:0]  cnt_q, cnt_d;

	always_comb begin
		logic              fall;
		logic              e0;
		logic              e1;
		logic              ef;
		logic [7:0]        c;
		logic [20:0]       acc_n;
		uf2a_pkg::result_t r0;
		uf2a_pkg::result_t r1;
		uf2a_pkg::result_t rf;
		fall   = 1'b1;
		e0     = 1'b0;
		e1     = 1'b0;
		ef     = 1'b0;
		c      = cnt_q;
		r0     = '0;
		r1     = '0;
		rf     = '0;
		need_d = need_q;
		acc_d  = acc_q;
		acc_n  = {acc_q[14:0], text_byte[5:0]};
		if (need_q != 2'd0) begin
			if (cnt_q >= maxlen_q) begin
				need_d = 2'd0;
				acc_d  = '0;
			end else if (text_byte[7:6] == 2'b10) begin
				fall   = 1'b0;
				acc_d  = acc_n;
				need_d = need_q - 2'd1;
				if (need_q == 2'd1) begin
					c              = cnt_q + 8'd1;
					e0             = 1'b1;
					r0.folded_char = uf2a_pkg::fold_cp(acc_n);
					r0.char_count  = c;
				end
			end else begin
				// A sequence cut short gives a dot; the byte is then taken afresh.
				need_d         = 2'd0;
				acc_d          = '0;
				c              = cnt_q + 8'd1;
				e0             = 1'b1;
				r0.folded_char = uf2a_pkg::CH_DOT;
				r0.char_count  = c;
			end
		end
		if (fall) begin
			if (text_byte == 8'd0) begin
				ef             = 1'b1;
				rf.folded_char = uf2a_pkg::CH_NUL;
				rf.char_count  = c;
				rf.end_of_text = 1'b1;
				c              = 8'd0;
				need_d         = 2'd0;
				acc_d          = '0;
			end else if (c < maxlen_q) begin
				if (!text_byte[7]) begin
					ef             = 1'b1;
					c              = c + 8'd1;
					rf.folded_char = (text_byte >= 8'h20) ? text_byte[6:0]
						: uf2a_pkg::CH_SPACE;
					rf.char_count  = c;
				end else if (text_byte[7:5] == 3'b110) begin
					acc_d  = {16'd0, text_byte[4:0]};
					need_d = 2'd1;
				end else if (text_byte[7:4] == 4'b1110) begin
					acc_d  = {17'd0, text_byte[3:0]};
					need_d = 2'd2;
				end else if (text_byte[7:3] == 5'b11110) begin
					acc_d  = {18'd0, text_byte[2:0]};
					need_d = 2'd3;
				end else begin
					ef             = 1'b1;
					c              = c + 8'd1;
					rf.folded_char = uf2a_pkg::CH_DOT;
					rf.char_count  = c;
				end
			end
		end
		if (ef) begin
			if (e0) begin
				e1 = 1'b1;
				r1 = rf;
			end else begin
				e0 = 1'b1;
				r0 = rf;
			end
		end
		if (e1) begin
			r1.last_in_run = 1'b1;
		end else begin
			r0.last_in_run = 1'b1;
		end
		cnt_d  = c;
		rec.two = e1;
		rec.r0  = r0;
		rec.r1  = r1;
		push    = accept && e0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxlen_q <= 8'hff;
			need_q   <= 2'd0;
			acc_q    <= '0;
			cnt_q    <= 8'd0;
		end else begin
			if (cfg_valid) begin
				maxlen_q <= cfg_data;
			end
			if (accept) begin
				need_q <= need_d;
				acc_q  <= acc_d;
				cnt_q  <= cnt_d;
			end
		end
	end

endmodule

[hdl/uf2a_queue.sv]
module uf2a_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  uf2a_pkg::record_t    push_rec,
	input  logic                 pop,
	output uf2a_pkg::record_t    head,
	output uf2a_pkg::q_stat_t    stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	uf2a_pkg::record_t mem_q [DEPTH];
	logic [PW-1:0]     wptr_q, rptr_q;
	logic [CW-1:0]     cnt_q;

	assign head       = mem_q[rptr_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[hdl/uf2a_back.sv]
module uf2a_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uf2a_pkg::record_t    head,
	input  uf2a_pkg::q_stat_t    stat,
	output logic                 pop,
	input  logic                 out_ready,
	output logic                 out_valid,
	output uf2a_pkg::result_t    out_res
);

	logic              valid_q;
	logic              sel_q;
	logic              load;
	logic              take;
	uf2a_pkg::result_t res_q;

	assign load      = !valid_q || out_ready;
	assign take      = load && !stat.empty;
	assign pop       = take && (sel_q || !head.two);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= sel_q ? head.r1 : head.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !stat.empty;
			end
			if (take) begin
				sel_q <= !pop;
			end
		end
	end

endmodule

[hdl/utf8_fold_to_ascii_core.sv]
// UTF-8 to ASCII folding core.
// Bytes of text arrive on the s_ side, one transfer per byte; a zero byte ends
// the text. Each decoded character leaves on the m_ side as one ASCII character
// with the running count; a zero byte also yields an end-of-text transfer that
// carries the total count, with m_tuser high. m_tlast marks the last result
// caused by one input byte, and each byte causes zero, one or two results.
// The cfg channel writes the maximum length and is always ready.
// Results pass from the decoder through the queue and the output register.
// One byte is taken every cycle while s_tready is high; the output moves one
// result per cycle while m_tready is high, so a byte causing two results
// holds the output longer, and a queue of QUEUE_DEPTH entries absorbs this.
// When the receiver stalls, the queue fills and s_tready drops once it is full.
// Reset clears the decoder state and the queue, and sets the maximum length
// to 255.
`include "assert_macros.svh"

module utf8_fold_to_ascii_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // max_length
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // folded_char [6:0], char_count [14:7], zero
	output logic        m_tuser,     // end_of_text
	output logic        m_tlast      // last_in_run
);

	logic                 accept;
	logic                 push;
	logic                 pop;
	uf2a_pkg::record_t    rec;
	uf2a_pkg::record_t    head;
	uf2a_pkg::q_stat_t    stat;
	uf2a_pkg::result_t    res;

	assign cfg_ready = 1'b1;
	assign s_tready  = !stat.full;
	assign accept    = s_tvalid && s_tready;

	uf2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.text_byte (s_tdata),
		.push      (push),
		.rec       (rec)
	);

	uf2a_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (rec),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	uf2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.char_count, res.folded_char};
	assign m_tuser = res.end_of_text;
	assign m_tlast = res.last_in_run;

	`ASSERT_CLK(a_eot_no_char, m_tvalid && m_tuser |-> m_tdata[6:0] == 7'd0, "end-of-text carries a character")
	`ASSERT_CLK(a_eot_last, m_tvalid && m_tuser |-> m_tlast, "end-of-text result is not last")
	`ASSERT_NEVER(a_queue_flags, stat.full && stat.empty, "queue both full and empty")
	`ASSERT_NEVER(a_pop_empty, pop && stat.empty, "queue read while empty")

endmodule
